// File: hdl/assert_macros.svh
// assertion macros shared by the rtl files of the task queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define TCPQ_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: property failed");
// condition must never be seen outside reset
`define TCPQ_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define TCPQ_ASSERT(name, clk, rstn, prop)
`define TCPQ_NEVER(name, clk, rstn, expr)
`endif
`endif

// File: hdl/tcpq_pkg.sv
// types, codes and helper functions of the three class task queue
package tcpq_pkg;

  localparam int unsigned TASK_ID_BITS = 22;
  localparam int unsigned SLICE_W      = 32;
  localparam int unsigned N_QUEUES     = 3;
  localparam int unsigned CFG_IDX_W    = 2;

  // queue numbers
  localparam logic [1:0] Q_LAT = 2'd0;
  localparam logic [1:0] Q_DEF = 2'd1;
  localparam logic [1:0] Q_BG  = 2'd2;

  // task class codes
  localparam logic [1:0] CLS_LAT  = 2'd0;
  localparam logic [1:0] CLS_DEF  = 2'd1;
  localparam logic [1:0] CLS_BG   = 2'd2;
  localparam logic [1:0] CLS_NONE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LAT_SLICE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_SLICE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_SLICE  = 2'd2;

  // slice values after reset, ns
  localparam logic [SLICE_W-1:0] LAT_SLICE_RST = 32'd5_000_000;
  localparam logic [SLICE_W-1:0] DEF_SLICE_RST = 32'd20_000_000;
  localparam logic [SLICE_W-1:0] BG_SLICE_RST  = 32'd2_000_000;

  typedef enum logic [1:0] {
    REQ_WAKE     = 2'd0,
    REQ_ENQUEUE  = 2'd1,
    REQ_DISPATCH = 2'd2,
    REQ_TICK     = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    STS_DIRECT     = 3'd0,
    STS_QUEUED     = 3'd1,
    STS_FULL       = 3'd2,
    STS_DISPATCHED = 3'd3,
    STS_EMPTY      = 3'd4,
    STS_PREEMPT    = 3'd5,
    STS_KEEP       = 3'd6,
    STS_NONE       = 3'd7
  } status_e;

  typedef enum logic [0:0] {
    CS_IDLE = 1'b0,
    CS_READ = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [TASK_ID_BITS-1:0] task_id;
    logic [1:0]              task_class;
    logic                    cpu_idle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [TASK_ID_BITS-1:0] out_task_id;
    logic [SLICE_W-1:0]      out_slice;
    logic [1:0]              out_queue;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // request taken this cycle
    logic load_rd;  // queue memory data is valid, load the dispatch result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read;  // current request pops a queue entry
    logic out_busy;   // result register holds a result that is stalled
  } dpath_sts_t;

  // unclassified tasks go to the default queue
  function automatic logic [1:0] queue_of_class(input logic [1:0] cls);
    logic [1:0] q;
    unique case (cls)
      CLS_LAT:  q = Q_LAT;
      CLS_BG:   q = Q_BG;
      CLS_DEF:  q = Q_DEF;
      CLS_NONE: q = Q_DEF;
    endcase
    return q;
  endfunction

  function automatic logic [SLICE_W-1:0] slice_sel(
    input logic [1:0]         q,
    input logic [SLICE_W-1:0] lat,
    input logic [SLICE_W-1:0] def,
    input logic [SLICE_W-1:0] bg
  );
    logic [SLICE_W-1:0] s;
    unique case (q)
      Q_LAT:   s = lat;
      Q_BG:    s = bg;
      default: s = def;
    endcase
    return s;
  endfunction

endpackage

// File: hdl/three_class_priority_task_queue.sv
// Strict priority task queue with latency, default and background FIFOs.
// Request channel: in_valid_i / in_stall_o with in_item_i (req_type, task_id,
// task_class, cpu_idle). A request is taken at a clock edge with valid high
// and stall low. Result channel: out_valid_o / out_stall_i with out_item_o;
// every request yields exactly one result, in request order.
// Wake, enqueue, tick and dispatch from empty queues answer in the cycle
// after the request is taken. A dispatch that pops an entry answers through
// the registered queue memory read port and then the result register, and
// in_stall_o stays high for the read state. So throughput is one request per
// cycle while in_stall_o is low; a popping dispatch holds off the next one.
// The result register frees the request side: a new request is taken while
// a result waits, unless that result is stalled, then in_stall_o is high
// until the receiver takes it.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (0 latency,
// 1 default, 2 background slice) and cfg_data_i; ready is always high and
// an index beyond the list is ignored. Write only while the block is idle.
// Reset empties all queues and restores the slices to 5, 20 and 2 ms; the
// queue memories need no clearing.
module three_class_priority_task_queue #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  tcpq_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output tcpq_pkg::out_item_t              out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tcpq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tcpq_pkg::SLICE_W-1:0]     cfg_data_i
);

  tcpq_pkg::ctrl_cmd_t  cmd;
  tcpq_pkg::dpath_sts_t sts;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  // request sequencer
  tcpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // queues, slices and result register
  tcpq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

// File: hdl/tcpq_ram.sv
// generic single write port, single read port ram with registered read
module tcpq_ram #(
  parameter int unsigned WIDTH = 22,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/tcpq_ctrl.sv
// request sequencer of the task queue: accept handshake and dispatch read wait
`include "assert_macros.svh"

module tcpq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  tcpq_pkg::dpath_sts_t   sts_i,
  output tcpq_pkg::ctrl_cmd_t    cmd_o
);

  tcpq_pkg::ctrl_state_e state_q, state_d;
  logic                  accept;

  // a request is taken only in idle with no stalled result in the result register
  assign in_stall_o = (state_q != tcpq_pkg::CS_IDLE) || sts_i.out_busy;
  assign accept     = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcpq_pkg::CS_IDLE: begin
        if (accept && sts_i.need_read) begin
          state_d = tcpq_pkg::CS_READ;
        end
      end
      tcpq_pkg::CS_READ: begin
        state_d = tcpq_pkg::CS_IDLE;
      end
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd_o.accept  = accept;
    cmd_o.load_rd = (state_q == tcpq_pkg::CS_READ);
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcpq_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TCPQ_ASSERT(a_read_one_cycle, clk_i, rst_ni, (state_q == tcpq_pkg::CS_READ) |=> (state_q == tcpq_pkg::CS_IDLE))
  `TCPQ_ASSERT(a_pop_then_load, clk_i, rst_ni, (cmd_o.accept && sts_i.need_read) |=> cmd_o.load_rd)
  `TCPQ_NEVER(a_no_accept_in_read, clk_i, rst_ni, cmd_o.accept && cmd_o.load_rd)

endmodule

// File: hdl/tcpq_dpath.sv
// datapath of the task queue: slice registers, queue pointers, queue memories, result register
`include "assert_macros.svh"

module tcpq_dpath #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tcpq_pkg::in_item_t                   in_item_i,
  input  tcpq_pkg::ctrl_cmd_t                  cmd_i,
  output tcpq_pkg::dpath_sts_t                 sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output tcpq_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_we_i,
  input  logic [tcpq_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tcpq_pkg::SLICE_W-1:0]         cfg_data_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
  localparam int unsigned NQ = tcpq_pkg::N_QUEUES;
  localparam int unsigned IDW = tcpq_pkg::TASK_ID_BITS;

  logic [tcpq_pkg::SLICE_W-1:0] lat_slice_q, def_slice_q, bg_slice_q;

  logic [PTR_W-1:0] head_q   [NQ];
  logic [PTR_W-1:0] head_nxt [NQ];
  logic [CNT_W-1:0] count_q  [NQ];
  logic [SUM_W-1:0] tail_sum [NQ];
  logic [PTR_W-1:0] tail     [NQ];
  logic [IDW-1:0]   rd_data  [NQ];
  logic [NQ-1:0]    full, nonempty, enq_go, pop_go;

  tcpq_pkg::req_type_e req;
  logic [1:0]          q;
  logic [1:0]          disp_sel;
  logic                any_ne;
  logic [1:0]          disp_q_q;
  logic                out_valid_q;
  tcpq_pkg::out_item_t out_item_q;
  tcpq_pkg::out_item_t imm_item, rd_item;

  // request decode
  assign req = tcpq_pkg::req_type_e'(in_item_i.req_type);
  assign q   = tcpq_pkg::queue_of_class(in_item_i.task_class);

  // slice registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_slice_q <= tcpq_pkg::LAT_SLICE_RST;
      def_slice_q <= tcpq_pkg::DEF_SLICE_RST;
      bg_slice_q  <= tcpq_pkg::BG_SLICE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tcpq_pkg::CFG_LAT_SLICE: lat_slice_q <= cfg_data_i;
        tcpq_pkg::CFG_DEF_SLICE: def_slice_q <= cfg_data_i;
        tcpq_pkg::CFG_BG_SLICE:  bg_slice_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // highest priority non-empty queue
  always_comb begin
    any_ne   = 1'b1;
    disp_sel = tcpq_pkg::Q_LAT;
    priority if (nonempty[tcpq_pkg::Q_LAT]) begin
      disp_sel = tcpq_pkg::Q_LAT;
    end else if (nonempty[tcpq_pkg::Q_DEF]) begin
      disp_sel = tcpq_pkg::Q_DEF;
    end else if (nonempty[tcpq_pkg::Q_BG]) begin
      disp_sel = tcpq_pkg::Q_BG;
    end else begin
      any_ne = 1'b0;
    end
  end

  // per queue pointers, fill state and push / pop strobes
  always_comb begin
    for (int k = 0; k < NQ; k++) begin
      nonempty[k] = (count_q[k] != '0);
      full[k]     = (count_q[k] == FULL_CNT);
      tail_sum[k] = SUM_W'(head_q[k]) + SUM_W'(count_q[k]);
      if (tail_sum[k] >= DEPTH_SUM) begin
        tail_sum[k] = tail_sum[k] - DEPTH_SUM;
      end
      tail[k]     = tail_sum[k][PTR_W-1:0];
      head_nxt[k] = (head_q[k] == LAST_PTR) ? '0 : head_q[k] + PTR_W'(1);
      enq_go[k]   = cmd_i.accept && (req == tcpq_pkg::REQ_ENQUEUE) &&
                    (q == 2'(k)) && !full[k];
      pop_go[k]   = cmd_i.accept && (req == tcpq_pkg::REQ_DISPATCH) &&
                    any_ne && (disp_sel == 2'(k));
    end
  end

  // queue pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NQ; k++) begin
        head_q[k]  <= '0;
        count_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NQ; k++) begin
        if (enq_go[k]) begin
          count_q[k] <= count_q[k] + CNT_W'(1);
        end else if (pop_go[k]) begin
          count_q[k] <= count_q[k] - CNT_W'(1);
          head_q[k]  <= head_nxt[k];
        end
      end
    end
  end

  // one memory per queue
  for (genvar g = 0; g < NQ; g++) begin : g_queue
    tcpq_ram #(
      .WIDTH (IDW),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (enq_go[g]),
      .waddr_i (tail[g]),
      .wdata_i (in_item_i.task_id),
      .re_i    (pop_go[g]),
      .raddr_i (head_q[g]),
      .rdata_o (rd_data[g])
    );
  end

  // results that need no memory read
  always_comb begin
    imm_item.status      = tcpq_pkg::STS_NONE;
    imm_item.out_task_id = '0;
    imm_item.out_slice   = '0;
    imm_item.out_queue   = q;
    unique case (req)
      tcpq_pkg::REQ_WAKE: begin
        if (in_item_i.cpu_idle && (q != tcpq_pkg::Q_BG)) begin
          imm_item.status      = tcpq_pkg::STS_DIRECT;
          imm_item.out_task_id = in_item_i.task_id;
          imm_item.out_slice   = tcpq_pkg::slice_sel(q, lat_slice_q, def_slice_q, bg_slice_q);
        end
      end
      tcpq_pkg::REQ_ENQUEUE: begin
        if (full[q]) begin
          imm_item.status = tcpq_pkg::STS_FULL;
        end else begin
          imm_item.status    = tcpq_pkg::STS_QUEUED;
          imm_item.out_slice = tcpq_pkg::slice_sel(q, lat_slice_q, def_slice_q, bg_slice_q);
        end
      end
      tcpq_pkg::REQ_DISPATCH: begin
        // only the empty case is answered here
        imm_item.status    = tcpq_pkg::STS_EMPTY;
        imm_item.out_queue = tcpq_pkg::Q_LAT;
      end
      tcpq_pkg::REQ_TICK: begin
        if ((q != tcpq_pkg::Q_LAT) && nonempty[tcpq_pkg::Q_LAT]) begin
          imm_item.status = tcpq_pkg::STS_PREEMPT;
        end else begin
          imm_item.status = tcpq_pkg::STS_KEEP;
        end
      end
    endcase
  end

  // dispatch result from the popped entry
  always_comb begin
    rd_item.status    = tcpq_pkg::STS_DISPATCHED;
    rd_item.out_slice = tcpq_pkg::slice_sel(disp_q_q, lat_slice_q, def_slice_q, bg_slice_q);
    rd_item.out_queue = disp_q_q;
    unique case (disp_q_q)
      tcpq_pkg::Q_LAT: rd_item.out_task_id = rd_data[tcpq_pkg::Q_LAT];
      tcpq_pkg::Q_BG:  rd_item.out_task_id = rd_data[tcpq_pkg::Q_BG];
      default:         rd_item.out_task_id = rd_data[tcpq_pkg::Q_DEF];
    endcase
  end

  // queue being popped, held for the read cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && sts_o.need_read) begin
      disp_q_q <= disp_sel;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_rd || (cmd_i.accept && !sts_o.need_read)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rd) begin
      out_item_q <= rd_item;
    end else if (cmd_i.accept && !sts_o.need_read) begin
      out_item_q <= imm_item;
    end
  end

  // status to the controller
  always_comb begin
    sts_o.need_read = (req == tcpq_pkg::REQ_DISPATCH) && any_ne;
    sts_o.out_busy  = out_valid_q && out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `TCPQ_NEVER(a_load_into_busy, clk_i, rst_ni, cmd_i.load_rd && out_valid_q)
  `TCPQ_NEVER(a_count_bound, clk_i, rst_ni, (count_q[0] > FULL_CNT) || (count_q[1] > FULL_CNT) || (count_q[2] > FULL_CNT))
  `TCPQ_NEVER(a_one_queue_moves, clk_i, rst_ni, ((enq_go != '0) || (pop_go != '0)) && !$onehot(enq_go | pop_go))

endmodule

// File: verif/three_class_priority_task_queue_tb.sv
// self-checking testbench of the three class priority task queue
module three_class_priority_task_queue_tb;
  import tcpq_pkg::*;

  localparam int unsigned QDEPTH        = 256;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned MAX_REPORTS   = 10;

  // index beyond the register list, the block ignores it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    RX_OPEN  = 2'd0,
    RX_LIGHT = 2'd1,
    RX_HALF  = 2'd2,
    RX_HEAVY = 2'd3
  } rx_mode_e;

  logic                    clk;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  in_item_t                in_item   = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b1;
  out_item_t               out_item;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_LAT_SLICE;
  logic [SLICE_W-1:0]      cfg_data  = '0;

  // requests waiting for the driver, results waiting for the monitor
  in_item_t                req_backlog[$];
  out_item_t               expected_results[$];

  // scheduler state as the testbench sees it
  logic [TASK_ID_BITS-1:0] lat_ids[$];
  logic [TASK_ID_BITS-1:0] def_ids[$];
  logic [TASK_ID_BITS-1:0] bg_ids[$];
  logic [SLICE_W-1:0]      lat_slice = LAT_SLICE_RST;
  logic [SLICE_W-1:0]      def_slice = DEF_SLICE_RST;
  logic [SLICE_W-1:0]      bg_slice  = BG_SLICE_RST;

  int unsigned             fail_count      = 0;
  int unsigned             holds_requested = 0;
  int unsigned             holds_started   = 0;
  int unsigned             hold_left       = 0;
  int unsigned             burst_left      = 1;
  int unsigned             gap_left        = 0;
  int unsigned             mode_left       = 0;
  int unsigned             quiet_cycles    = 0;
  rx_mode_e                rx_mode         = RX_OPEN;

  three_class_priority_task_queue #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [SLICE_W-1:0] slice_for(input logic [1:0] q);
    if (q == Q_LAT) return lat_slice;
    if (q == Q_BG) return bg_slice;
    return def_slice;
  endfunction

  // expected scheduler answer to one request, updates the queue state
  function automatic out_item_t predict_result(input in_item_t req);
    out_item_t  res;
    logic [1:0] q;
    int unsigned fill;
    q = (req.task_class == CLS_LAT) ? Q_LAT : (req.task_class == CLS_BG) ? Q_BG : Q_DEF;
    fill = (q == Q_LAT) ? lat_ids.size() : (q == Q_BG) ? bg_ids.size() : def_ids.size();
    res = '0;
    res.status = STS_NONE;
    res.out_queue = q;
    case (req.req_type)
      REQ_WAKE: begin
        if (req.cpu_idle && q != Q_BG) begin
          res.status = STS_DIRECT;
          res.out_task_id = req.task_id;
          res.out_slice = slice_for(q);
        end
      end
      REQ_ENQUEUE: begin
        if (fill >= QDEPTH) begin
          res.status = STS_FULL;
        end else begin
          if (q == Q_LAT) lat_ids.push_back(req.task_id);
          else if (q == Q_BG) bg_ids.push_back(req.task_id);
          else def_ids.push_back(req.task_id);
          res.status = STS_QUEUED;
          res.out_slice = slice_for(q);
        end
      end
      REQ_DISPATCH: begin
        // strict priority: latency, then default, then background
        res.status = STS_EMPTY;
        res.out_queue = Q_LAT;
        if (lat_ids.size() != 0) begin
          res.out_task_id = lat_ids.pop_front();
          res.out_queue = Q_LAT;
          res.status = STS_DISPATCHED;
        end else if (def_ids.size() != 0) begin
          res.out_task_id = def_ids.pop_front();
          res.out_queue = Q_DEF;
          res.status = STS_DISPATCHED;
        end else if (bg_ids.size() != 0) begin
          res.out_task_id = bg_ids.pop_front();
          res.out_queue = Q_BG;
          res.status = STS_DISPATCHED;
        end
        if (res.status == STS_DISPATCHED) res.out_slice = slice_for(res.out_queue);
      end
      default: begin
        res.status = (q != Q_LAT && lat_ids.size() != 0) ? STS_PREEMPT : STS_KEEP;
      end
    endcase
    return res;
  endfunction

  task automatic report_failure(input string what, input out_item_t want,
                                input out_item_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display({"%s: expected status %0d id %h slice %h queue %0d,",
                " got status %0d id %h slice %h queue %0d"},
               what, want.status, want.out_task_id, want.out_slice, want.out_queue,
               got.status, got.out_task_id, got.out_slice, got.out_queue);
    end
  endtask

  function automatic in_item_t make_request(input req_type_e op, input logic [1:0] cls,
                                            input logic [TASK_ID_BITS-1:0] id,
                                            input logic idle);
    in_item_t req;
    req.req_type = op;
    req.task_class = cls;
    req.task_id = id;
    req.cpu_idle = idle;
    return req;
  endfunction

  // random requests with a given operation mix and a favored class
  task automatic queue_random_requests(input int count, input int enq_pct, input int deq_pct,
                                       input int wake_pct, input logic [1:0] fav_cls,
                                       input int fav_pct);
    in_item_t req;
    int       r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < enq_pct) req.req_type = REQ_ENQUEUE;
      else if (r < enq_pct + deq_pct) req.req_type = REQ_DISPATCH;
      else if (r < enq_pct + deq_pct + wake_pct) req.req_type = REQ_WAKE;
      else req.req_type = REQ_TICK;
      if ($urandom_range(0, 99) < fav_pct) req.task_class = fav_cls;
      else req.task_class = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 15))
        0:       req.task_id = '0;
        1:       req.task_id = '1;
        default: req.task_id = TASK_ID_BITS'($urandom());
      endcase
      req.cpu_idle = 1'($urandom_range(0, 1));
      req_backlog.push_back(req);
    end
  endtask

  // returns once every request is answered and the block has settled
  task automatic wait_idle();
    while (req_backlog.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all slice registers, optionally the unused index as well
  task automatic program_slices(input logic [SLICE_W-1:0] lat, input logic [SLICE_W-1:0] dflt,
                                input logic [SLICE_W-1:0] bg, input bit touch_unused);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [SLICE_W-1:0]   val [4];
    int                   n;
    idx[0] = CFG_LAT_SLICE;
    idx[1] = CFG_DEF_SLICE;
    idx[2] = CFG_BG_SLICE;
    idx[3] = CFG_UNUSED;
    val[0] = lat;
    val[1] = dflt;
    val[2] = bg;
    val[3] = $urandom();
    n = touch_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        CFG_LAT_SLICE: lat_slice = val[i];
        CFG_DEF_SLICE: def_slice = val[i];
        CFG_BG_SLICE:  bg_slice  = val[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // request driver: bursts of random length with random gaps
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        in_item  <= req_backlog.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: long hold when asked, otherwise a changing stall mix
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      mode_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_started < holds_requested) begin
      holds_started <= holds_started + 1;
      hold_left     <= LONG_HOLD;
      out_stall     <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(10, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HALF:  out_stall <= 1'($urandom_range(0, 1));
        default:  out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result check against the oldest expectation, then prediction of new requests
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_failure("unexpected result", '0, out_item);
        end else begin
          want = expected_results.pop_front();
          if (out_item.status !== want.status || out_item.out_task_id !== want.out_task_id
              || out_item.out_slice !== want.out_slice
              || out_item.out_queue !== want.out_queue) begin
            report_failure("result mismatch", want, out_item);
          end
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(predict_result(in_item));
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: wakes, empty dispatch, enqueues, ticks with and without latency work, dispatches
    req_backlog.push_back(make_request(REQ_DISPATCH, CLS_NONE, '1, 1'b1));
    req_backlog.push_back(make_request(REQ_WAKE, CLS_LAT, '1, 1'b1));
    req_backlog.push_back(make_request(REQ_WAKE, CLS_DEF, '0, 1'b1));
    req_backlog.push_back(make_request(REQ_WAKE, CLS_BG, 22'h2AAAAA, 1'b1));
    req_backlog.push_back(make_request(REQ_WAKE, CLS_NONE, 22'h155555, 1'b1));
    req_backlog.push_back(make_request(REQ_WAKE, CLS_LAT, 22'h3FFFFF, 1'b0));
    req_backlog.push_back(make_request(REQ_TICK, CLS_DEF, '0, 1'b0));
    req_backlog.push_back(make_request(REQ_ENQUEUE, CLS_BG, 22'h155555, 1'b0));
    req_backlog.push_back(make_request(REQ_ENQUEUE, CLS_NONE, 22'h2AAAAA, 1'b1));
    req_backlog.push_back(make_request(REQ_ENQUEUE, CLS_DEF, '1, 1'b0));
    req_backlog.push_back(make_request(REQ_ENQUEUE, CLS_LAT, '0, 1'b1));
    req_backlog.push_back(make_request(REQ_ENQUEUE, CLS_LAT, '1, 1'b0));
    req_backlog.push_back(make_request(REQ_TICK, CLS_LAT, '1, 1'b1));
    req_backlog.push_back(make_request(REQ_TICK, CLS_DEF, '0, 1'b0));
    req_backlog.push_back(make_request(REQ_TICK, CLS_BG, '1, 1'b1));
    req_backlog.push_back(make_request(REQ_TICK, CLS_NONE, '0, 1'b0));
    repeat (6) req_backlog.push_back(make_request(REQ_DISPATCH, CLS_LAT, '0, 1'b0));
    req_backlog.push_back(make_request(REQ_TICK, CLS_BG, '0, 1'b1));
    wait_idle();

    // mixed traffic at reset slices
    queue_random_requests(300, 35, 30, 20, CLS_LAT, 0);
    wait_idle();

    // zero slices, the unused index written too
    program_slices('0, '0, '0, 1'b1);
    queue_random_requests(200, 35, 30, 20, CLS_DEF, 0);
    wait_idle();

    // all-ones slices, entries left from before dispatch with the new values
    program_slices('1, '1, '1, 1'b0);
    queue_random_requests(200, 30, 35, 20, CLS_BG, 0);
    wait_idle();

    // fill one class past its depth while the receiver holds off
    program_slices($urandom(), $urandom(), $urandom(), 1'b0);
    holds_requested++;
    queue_random_requests(450, 90, 3, 4, 2'($urandom_range(0, 3)), 70);
    wait_idle();

    // drain with mostly dispatches
    program_slices($urandom(), $urandom(), $urandom(), 1'b1);
    queue_random_requests(350, 10, 70, 10, CLS_NONE, 0);
    wait_idle();

    // final mix at random slices
    program_slices($urandom(), $urandom(), $urandom(), 1'b0);
    queue_random_requests(250, 35, 30, 20, CLS_LAT, 0);
    wait_idle();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tcpq_pkg.sv
hdl/tcpq_ram.sv
hdl/tcpq_ctrl.sv
hdl/tcpq_dpath.sv
hdl/three_class_priority_task_queue.sv
verif/three_class_priority_task_queue_tb.sv
